[hw/rtl/cls_pkg.sv]
// shared types and constants for the compacting list store
// no dependencies; imported by every module of the block
`default_nettype none

package cls_pkg;

    localparam int C_CAPACITY   = 16;
    localparam int C_WORD_WIDTH = 32;
    localparam int C_CNT_W      = $clog2(C_CAPACITY + 1);
    localparam int C_IDX_W      = $clog2(C_CAPACITY);

    typedef logic [C_WORD_WIDTH-1:0] t_word;
    typedef logic [C_CNT_W-1:0]      t_count;

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_REMOVE_AT    = 3'd1,
        CMD_REMOVE_ALL   = 3'd2,
        CMD_REMOVE_FIRST = 3'd3,
        CMD_EXISTS       = 3'd4,
        CMD_REPLACE      = 3'd5,
        CMD_READ         = 3'd6,
        CMD_COUNT        = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT
    } t_state;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;       // transaction accepted this cycle
        logic by_value;   // mark entries equal to the value
        logic by_index;   // mark the selected entry
        logic replace;    // overwrite equal entries with the new word
        logic append;     // write the value into the first free cell
        logic shift;      // close the gap at the lowest mark
        logic keep_marks; // marks travel with the shift (remove all)
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/cls_cell.sv]
// one list cell: a stored word, its removal mark and the shift-down path
// depends on cls_pkg
`default_nettype none

module cls_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire cls_pkg::t_cell_ctl i_ctl,
    input  wire                     i_valid,
    input  wire                     i_sel,
    input  wire                     i_append_here,
    input  wire cls_pkg::t_word     i_value,
    input  wire cls_pkg::t_word     i_new_value,
    input  wire cls_pkg::t_word     i_up_word,
    input  wire                     i_up_mark,
    input  wire                     i_carry,
    output cls_pkg::t_word          o_word,
    output logic                    o_mark,
    output logic                    o_carry
);
    import cls_pkg::*;

    t_word r_word;
    logic  r_mark;
    logic  w_eq;

    assign w_eq    = (r_word == i_value);
    assign o_carry = i_carry | r_mark;
    assign o_word  = r_word;
    assign o_mark  = r_mark;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (i_ctl.append && i_append_here) begin
                r_word <= i_value;
            end else if (i_ctl.replace && i_valid && w_eq) begin
                r_word <= i_new_value;
            end
        end else if (i_ctl.shift && o_carry) begin
            r_word <= i_up_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else if (i_ctl.load) begin
            r_mark <= i_valid && ((i_ctl.by_value && w_eq) || (i_ctl.by_index && i_sel));
        end else if (i_ctl.shift) begin
            if (!i_ctl.keep_marks) begin
                r_mark <= 1'b0;
            end else if (o_carry) begin
                r_mark <= i_up_mark;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/compacting_list_store.sv]
// compacting list store: ordered, gap-free list held in a chain of cells
// depends on cls_pkg and cls_cell
// every command except remove all goes from accept through the eval state to the o_done pulse;
//   remove all with m >= 1 matches also passes the shift state (one gap closed per cycle)
// a new transaction is accepted only once the last one has finished;
//   busy drops in the cycle of o_done
// the gap position ripples through the cells as a carry, one removal per cycle
// reset (synchronous, active low) empties the list and clears all marks
`default_nettype none

module compacting_list_store (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_cmd,
    input  wire  [3:0]  i_index,
    input  wire  [31:0] i_value,
    input  wire  [31:0] i_new_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_read_word,
    output logic [4:0]  o_entry_count
);
    import cls_pkg::*;

    // control state
    t_state  r_state, n_state;
    t_count  r_count, n_count;
    t_cmd    r_cmd;
    logic    r_by_value;
    logic    r_done, n_done;
    logic    r_found, n_found;
    // result payload captured at accept
    t_status r_status;
    t_word   r_read_word;

    t_cmd      w_cmd;
    t_word     w_value, w_new_value;
    logic      w_accept;
    logic      w_by_value;
    logic      w_is_remove;
    logic      w_shift;
    logic      w_any_mark;
    logic      w_range_ok;
    t_cell_ctl w_ctl;

    // chain wiring; the extra slot at the top feeds the last cell
    logic [C_CAPACITY:0] w_carry;
    t_word               w_word [C_CAPACITY+1];
    logic                w_mark [C_CAPACITY+1];

    assign w_cmd       = t_cmd'(i_cmd);
    assign w_value     = C_WORD_WIDTH'(i_value);
    assign w_new_value = C_WORD_WIDTH'(i_new_value);
    assign w_accept    = start && !busy;
    assign w_by_value  = (w_cmd == CMD_REMOVE_ALL) || (w_cmd == CMD_REMOVE_FIRST)
                      || (w_cmd == CMD_EXISTS) || (w_cmd == CMD_REPLACE);
    assign w_range_ok  = (C_CNT_W'(i_index) < r_count);
    assign w_is_remove = (r_cmd == CMD_REMOVE_AT) || (r_cmd == CMD_REMOVE_ALL)
                      || (r_cmd == CMD_REMOVE_FIRST);
    assign w_any_mark  = w_carry[C_CAPACITY];
    // one gap closes per cycle while a removal still has a marked cell
    assign w_shift     = (r_state != ST_IDLE) && w_is_remove && w_any_mark;

    always_comb begin
        w_ctl.load       = w_accept;
        w_ctl.by_value   = w_by_value;
        w_ctl.by_index   = (w_cmd == CMD_REMOVE_AT);
        w_ctl.replace    = (w_cmd == CMD_REPLACE);
        w_ctl.append     = (w_cmd == CMD_APPEND);
        w_ctl.shift      = w_shift;
        w_ctl.keep_marks = (r_cmd == CMD_REMOVE_ALL);
    end

    assign w_carry[0]         = 1'b0;
    assign w_word[C_CAPACITY] = '0;
    assign w_mark[C_CAPACITY] = 1'b0;

    for (genvar gi = 0; gi < C_CAPACITY; gi++) begin : g_cell
        cls_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_valid       (C_CNT_W'(gi) < r_count),
            .i_sel         (C_CNT_W'(gi) == C_CNT_W'(i_index)),
            .i_append_here (C_CNT_W'(gi) == r_count),
            .i_value       (w_value),
            .i_new_value   (w_new_value),
            .i_up_word     (w_word[gi+1]),
            .i_up_mark     (w_mark[gi+1]),
            .i_carry       (w_carry[gi]),
            .o_word        (w_word[gi]),
            .o_mark        (w_mark[gi]),
            .o_carry       (w_carry[gi+1])
        );
    end

    // next state, count, match flag and result strobe
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_found = r_found;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                    if (w_cmd == CMD_APPEND && r_count < C_CNT_W'(C_CAPACITY)) begin
                        n_count = r_count + t_count'(1);
                    end
                end
            end
            ST_EVAL: begin
                // marks were set at accept: any survivor means a match
                n_found = w_any_mark && r_by_value;
                if (w_shift) begin
                    n_count = r_count - t_count'(1);
                end
                if (w_shift && r_cmd == CMD_REMOVE_ALL) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (w_shift) begin
                    n_count = r_count - t_count'(1);
                end else begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_found <= n_found;
        end
    end

    // command and payload captured with the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= w_cmd;
            r_by_value  <= w_by_value;
            r_status    <= STS_OK;
            r_read_word <= '0;
            case (w_cmd)
                CMD_APPEND: begin
                    if (r_count >= C_CNT_W'(C_CAPACITY)) begin
                        r_status <= STS_FULL;
                    end
                end
                CMD_REMOVE_AT: begin
                    if (!w_range_ok) begin
                        r_status <= STS_RANGE;
                    end
                end
                CMD_READ: begin
                    if (!w_range_ok) begin
                        r_status <= STS_RANGE;
                    end else begin
                        r_read_word <= w_word[C_IDX_W'(i_index)];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_word   = 32'(r_read_word);
    assign o_entry_count = 5'(r_count);

endmodule

`default_nettype wire

[hw/rtl/cls_checker.sv]
// port-level checks for the compacting list store, bound to the top level
// depends on cls_pkg and compacting_list_store
`default_nettype none

module cls_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    input  wire        busy,
    input  wire        o_done,
    input  wire [1:0]  o_status,
    input  wire        o_found,
    input  wire [31:0] o_read_word,
    input  wire [4:0]  o_entry_count
);
    import cls_pkg::*;

    // an accepted transaction keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // no two results in adjacent cycles
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on two adjacent cycles");

    // a full append leaves the list at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STS_FULL |-> o_entry_count == 5'(C_CAPACITY))
        else $error("full status with list below capacity");

    // a failed command reports no match and no word
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != STS_OK |-> !o_found && o_read_word == '0)
        else $error("error result carries match or word");

    // the count at each result never exceeds capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_entry_count <= 5'(C_CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind compacting_list_store cls_checker u_cls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_found       (o_found),
    .o_read_word   (o_read_word),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the compacting list store (start/busy commands, o_done results)
// depends on cls_pkg and compacting_list_store; predicts every result with its own list model
`timescale 1ns / 1ps

module tb_top;
    import cls_pkg::*;

    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_ITEMS = 1900;
    localparam t_word WORD_A      = 32'h1234_5678;
    localparam t_word WORD_B      = 32'hA5A5_5A5A;
    localparam t_word WORD_C      = 32'h8000_0001;
    localparam t_word WORD_D      = 32'h0F0F_F0F0;
    localparam t_word WORD_ABSENT = 32'hDEAD_BEEF;

    // one expected result, in port order
    typedef struct packed {
        t_status    status;
        logic       found;
        t_word      read_word;
        t_count     entry_count;
    } t_list_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [3:0]  i_index;
    logic [31:0] i_value;
    logic [31:0] i_new_value;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_found;
    logic [31:0] o_read_word;
    logic [4:0]  o_entry_count;

    // own copy of the list contents and its occupancy
    t_word stored_words [C_CAPACITY];
    int    stored_len;

    t_list_result pending_results [$];
    int           fail_count;
    int           cycle_count;
    bit           quiet_sender;   // set for the stretches with no random idle gaps

    compacting_list_store i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_new_value  (i_new_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_read_word  (o_read_word),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // apply one command to the list copy and return the result it gives
    function automatic t_list_result list_apply(t_cmd op, logic [3:0] idx, t_word val,
                                                t_word new_val);
        t_list_result res;
        int i;
        int keep;
        int first_hit;
        res.status    = STS_OK;
        res.found     = 1'b0;
        res.read_word = '0;
        first_hit     = -1;
        case (op)
            CMD_APPEND: begin
                if (stored_len >= C_CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    stored_words[stored_len] = val;
                    stored_len++;
                end
            end
            CMD_REMOVE_AT: begin
                if (idx >= stored_len) begin
                    res.status = STS_RANGE;
                end else begin
                    for (i = idx; i < stored_len - 1; i++)
                        stored_words[i] = stored_words[i + 1];
                    stored_len--;
                end
            end
            CMD_REMOVE_ALL: begin
                // survivors close up in their original order
                keep = 0;
                for (i = 0; i < stored_len; i++) begin
                    if (stored_words[i] == val) begin
                        res.found = 1'b1;
                    end else begin
                        stored_words[keep] = stored_words[i];
                        keep++;
                    end
                end
                stored_len = keep;
            end
            CMD_REMOVE_FIRST: begin
                for (i = 0; i < stored_len; i++)
                    if (first_hit < 0 && stored_words[i] == val)
                        first_hit = i;
                if (first_hit >= 0) begin
                    res.found = 1'b1;
                    for (i = first_hit; i < stored_len - 1; i++)
                        stored_words[i] = stored_words[i + 1];
                    stored_len--;
                end
            end
            CMD_EXISTS: begin
                for (i = 0; i < stored_len; i++)
                    if (stored_words[i] == val)
                        res.found = 1'b1;
            end
            CMD_REPLACE: begin
                // every match is judged against the old contents
                for (i = 0; i < stored_len; i++) begin
                    if (stored_words[i] == val) begin
                        res.found       = 1'b1;
                        stored_words[i] = new_val;
                    end
                end
            end
            CMD_READ: begin
                if (idx >= stored_len)
                    res.status = STS_RANGE;
                else
                    res.read_word = stored_words[idx];
            end
            default: ;
        endcase
        res.entry_count = t_count'(stored_len);
        return res;
    endfunction

    // random sender gap before a transaction, about a third of the time
    task automatic idle_gap();
        if (!quiet_sender && $urandom_range(0, 99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // offer one command and hold it until the block takes it
    task automatic send_cmd(t_cmd op, logic [3:0] idx, t_word val, t_word new_val);
        idle_gap();
        start       <= 1'b1;
        i_cmd       <= op;
        i_index     <= idx;
        i_value     <= val;
        i_new_value <= new_val;
        do @(posedge i_clk); while (busy !== 1'b0);
        // transaction accepted at this edge; start stays high for the caller
        pending_results.push_back(list_apply(op, idx, val, new_val));
    endtask

    // hold the sender off until every expected result has come back
    task automatic wait_for_drain();
        if (pending_results.size() != 0) begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // fill from empty with extreme words and duplicates, then append once more when full
    task automatic test_fill_and_overflow();
        int k;
        send_cmd(CMD_APPEND, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(CMD_APPEND, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(CMD_APPEND, 4'd3,  WORD_A, WORD_D);
        send_cmd(CMD_APPEND, 4'd7,  WORD_B, WORD_C);
        send_cmd(CMD_APPEND, 4'd1,  WORD_A, WORD_B);
        send_cmd(CMD_APPEND, 4'd9,  WORD_C, WORD_A);
        send_cmd(CMD_APPEND, 4'd2,  WORD_B, WORD_D);
        send_cmd(CMD_APPEND, 4'd12, WORD_A, WORD_C);
        for (k = 0; k < 8; k++)
            send_cmd(CMD_APPEND, 4'($urandom_range(0, 15)), $urandom, $urandom);
        // list is full now
        send_cmd(CMD_APPEND, 4'd0, WORD_D, WORD_D);
    endtask

    // read and remove by position, at both ends and out of range
    task automatic test_index_commands();
        send_cmd(CMD_READ,      4'd15, WORD_ABSENT, 32'h0);
        send_cmd(CMD_REMOVE_AT, 4'd15, 32'h0, 32'h0);
        send_cmd(CMD_READ,      4'd15, 32'h0, 32'h0);
        send_cmd(CMD_REMOVE_AT, 4'd15, 32'h0, 32'h0);
        send_cmd(CMD_REMOVE_AT, 4'd0,  32'h0, 32'h0);
    endtask

    // search, replace and the two removals by value, with and without matches, and a count
    task automatic test_value_commands();
        send_cmd(CMD_EXISTS,       4'd0, WORD_A, 32'h0);
        send_cmd(CMD_EXISTS,       4'd0, WORD_ABSENT, 32'h0);
        send_cmd(CMD_REPLACE,      4'd0, WORD_A, WORD_D);
        send_cmd(CMD_REMOVE_FIRST, 4'd0, WORD_B, 32'h0);
        send_cmd(CMD_REMOVE_ALL,   4'd0, WORD_D, 32'h0);
        send_cmd(CMD_REMOVE_ALL,   4'd0, WORD_ABSENT, 32'h0);
        send_cmd(CMD_COUNT,        4'd5, WORD_C, WORD_C);
    endtask

    // back-to-back commands, then the sender waits for every outstanding result
    task automatic test_sender_pause();
        int k;
        quiet_sender = 1'b1;
        for (k = 0; k < 4; k++)
            send_cmd(t_cmd'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     $urandom, $urandom);
        quiet_sender = 1'b0;
        wait_for_drain();
    endtask

    // long random mix; words drawn mostly from a small pool so that matches are common
    task automatic test_random_mix(int n_items);
        t_word      pool [4];
        int         k;
        int         p;
        int         append_pct;
        t_cmd       op;
        t_word      val;
        t_word      new_val;
        logic [3:0] idx;
        append_pct = 40;
        for (k = 0; k < n_items; k++) begin
            // the occupancy drifts between nearly empty and full
            if (k % 64 == 0) begin
                for (p = 0; p < 4; p++)
                    pool[p] = $urandom;
                append_pct = $urandom_range(15, 60);
            end
            if (k % 256 == 255)
                wait_for_drain();
            quiet_sender = (k >= 600 && k < 1000);
            if ($urandom_range(0, 99) < append_pct)
                op = CMD_APPEND;
            else
                op = t_cmd'($urandom_range(1, 7));
            val     = ($urandom_range(0, 9) == 0) ? t_word'($urandom)
                                                  : pool[$urandom_range(0, 3)];
            new_val = ($urandom_range(0, 1) == 0) ? t_word'($urandom)
                                                  : pool[$urandom_range(0, 3)];
            if (stored_len > 0 && $urandom_range(0, 3) != 0)
                idx = 4'($urandom_range(0, stored_len - 1));
            else
                idx = 4'($urandom_range(0, 15));
            send_cmd(op, idx, val, new_val);
        end
        quiet_sender = 1'b0;
    endtask

    // result checker: each o_done strobe is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d found %0d word %h count %0d",
                         $time, o_status, o_found, o_read_word, o_entry_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, o_found);
                    fail_count++;
                end
                if (o_read_word !== want.read_word) begin
                    $display("%0t: read_word expected %h actual %h",
                             $time, want.read_word, o_read_word);
                    fail_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_COUNT;
        i_index      = '0;
        i_value      = '0;
        i_new_value  = '0;
        stored_len   = 0;
        fail_count   = 0;
        cycle_count  = 0;
        quiet_sender = 1'b0;

        // single reset at the start of the run
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_overflow();
        test_index_commands();
        test_value_commands();
        test_sender_pause();
        test_random_mix(RANDOM_ITEMS);

        // let the last results come back, then idle before the verdict
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
